// ===== design/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, types and helper functions of the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // control to the cell row: shift toward the bottom or toward the top
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctl_t;

    typedef logic signed [2:0] rank_t;

    function automatic rank_t rank_of(input logic [7:0] c);
        rank_t r;
        unique case (c)
            CH_PLUS, CH_MINUS: r = 3'sd1;
            CH_STAR, CH_SLASH: r = 3'sd2;
            CH_CARET:          r = 3'sd3;
            default:           r = -3'sd1;
        endcase
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

// ===== design/itp_in_if.sv =====
// ----------------------------------------------------------------------------
// itp_in_if
// Valid/ready channel carrying one infix character per item.
// ----------------------------------------------------------------------------
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// ===== design/itp_out_if.sv =====
// ----------------------------------------------------------------------------
// itp_out_if
// Valid/ready channel carrying one postfix character per item.
// ----------------------------------------------------------------------------
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;
    logic       out_error;

    modport source (output valid, output out_char, output out_last, output out_error,
                    input ready);
    modport sink   (input valid, input out_char, input out_last, input out_error,
                    output ready);
endinterface

// ===== design/infix_to_postfix_converter_unit.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// usage:
//   infix channel takes one ascii character per item, in_last on the final one
//   postfix channel gives the postfix characters; a nul item with out_last
//   ends each expression, out_error flags overflow or an unmatched '('
//   operators sit in a row of shift cells, top of stack in the first cell
// flow:
//   an item is taken in the idle state and worked in the work state; each
//   operator popped to the output is one more pass through the work state
//   after the last item the flush state pops each leftover stack entry and
//   sees the stack empty, then the term state gives the nul
//   the first result is registered in the output register by the work state
// reset:
//   stack empty, error flag clear, no result pending
// stall:
//   a result waits in the output register; the unit holds while that register
//   is full and not taken, and takes no new item until the current is done
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit
    import itp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    itp_in_if.sink   infix,
    itp_out_if.source postfix
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WORK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_TERM  = 2'd3;

    localparam logic [1:0] K_LETTER = 2'd0;
    localparam logic [1:0] K_OPEN   = 2'd1;
    localparam logic [1:0] K_CLOSE  = 2'd2;
    localparam logic [1:0] K_OP     = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             err_reg, err_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [1:0]       kind_reg, kind_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;
    logic             out_error_reg, out_error_next;

    stk_ctl_t         ctl;
    logic [7:0]       top_data;
    logic             top_valid;
    logic             top_open;
    logic             rank_le;
    logic             out_free;
    logic             accept;
    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_last;
    logic [1:0]       done_state;
    logic [1:0]       in_kind;

    itp_stack u_stack (
        .clk       (clk),
        .ctl       (ctl),
        .push_data (char_reg),
        .top_data  (top_data)
    );

    assign infix.ready = (state_reg == S_IDLE);
    assign accept      = infix.valid && (state_reg == S_IDLE);
    assign out_free    = !out_valid_reg || postfix.ready;
    assign top_valid   = (count_reg != '0);
    assign top_open    = (top_data == CH_OPEN);
    assign rank_le     = (rank_of(char_reg) <= rank_of(top_data));
    assign done_state  = last_reg ? S_FLUSH : S_IDLE;

    always_comb
    begin
        priority if (is_letter(infix.in_char))
        begin
            in_kind = K_LETTER;
        end
        else if (infix.in_char == CH_OPEN)
        begin
            in_kind = K_OPEN;
        end
        else if (infix.in_char == CH_CLOSE)
        begin
            in_kind = K_CLOSE;
        end
        else
        begin
            in_kind = K_OP;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        ctl        = '0;
        emit       = 1'b0;
        emit_char  = top_data;
        emit_last  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    char_next  = infix.in_char;
                    last_next  = infix.in_last;
                    kind_next  = in_kind;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                unique case (kind_reg)
                    K_LETTER:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_char  = char_reg;
                            state_next = done_state;
                        end
                    end
                    K_CLOSE:
                    begin
                        priority if (top_valid && !top_open)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                ctl.pop    = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        else if (top_valid)
                        begin
                            ctl.pop    = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                            state_next = done_state;
                        end
                        else
                        begin
                            state_next = done_state;
                        end
                    end
                    K_OPEN, K_OP:
                    begin
                        priority if ((kind_reg == K_OP) && top_valid && !top_open && rank_le)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                ctl.pop    = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        else if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            err_next   = 1'b1;
                            state_next = done_state;
                        end
                        else
                        begin
                            ctl.push   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            state_next = done_state;
                        end
                    end
                    default:
                    begin
                        state_next = done_state;
                    end
                endcase
            end
            S_FLUSH:
            begin
                priority if (top_valid && top_open)
                begin
                    ctl.pop    = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    err_next   = 1'b1;
                end
                else if (top_valid)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        ctl.pop    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_NUL;
                    emit_last  = 1'b1;
                    err_next   = 1'b0;
                    count_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_error_next = out_error_reg;
        priority if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
            out_error_next = err_reg;
        end
        else if (postfix.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        last_reg      <= last_next;
        kind_reg      <= kind_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_error_reg <= out_error_next;
    end

    assign postfix.valid     = out_valid_reg;
    assign postfix.out_char  = out_char_reg;
    assign postfix.out_last  = out_last_reg;
    assign postfix.out_error = out_error_reg;

endmodule

// ===== design/itp_cell.sv =====
// ----------------------------------------------------------------------------
// itp_cell
// One entry of the operator stack; takes the entry above on a push and the
// entry below on a pop.
// ----------------------------------------------------------------------------
module itp_cell
    import itp_pkg::*;
(
    input  logic       clk,
    input  stk_ctl_t   ctl,
    input  logic [7:0] up_data,
    input  logic [7:0] down_data,
    output logic [7:0] data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        priority if (ctl.push)
        begin
            data_next = up_data;
        end
        else if (ctl.pop)
        begin
            data_next = down_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== design/itp_stack.sv =====
// ----------------------------------------------------------------------------
// itp_stack
// Row of stack cells; the top of stack sits in the first cell.
// ----------------------------------------------------------------------------
module itp_stack
    import itp_pkg::*;
(
    input  logic       clk,
    input  stk_ctl_t   ctl,
    input  logic [7:0] push_data,
    output logic [7:0] top_data
);

    logic [7:0] cell_data [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [7:0] up_in;
        logic [7:0] down_in;

        if (i == 0)
        begin : g_first
            assign up_in = push_data;
        end
        else
        begin : g_mid
            assign up_in = cell_data[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign down_in = CH_NUL;
        end
        else
        begin : g_above
            assign down_in = cell_data[i+1];
        end

        itp_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .up_data   (up_in),
            .down_data (down_in),
            .data      (cell_data[i])
        );
    end

    assign top_data = cell_data[0];

endmodule

// ===== tb/infix_to_postfix_converter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_tb
// Checks the shunting-yard converter: infix characters go in over the infix
// channel, and every postfix item that comes out is compared with the output
// of a behavioral operator-stack model kept inside this bench. A short table
// of directed items comes first, then random mostly well-formed expressions,
// broken sequences, raw bytes and deep nesting that can overflow the stack.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit_tb;
    import itp_pkg::*;

    localparam int RANDOM_ITEMS = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int NUM_ROWS     = 26;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } postfix_item_t;

    typedef struct packed {
        logic [7:0]    ch;
        logic          last;
        logic          typed;
        postfix_item_t result;
    } stim_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;
    typedef enum logic [1:0] {SEQ_EXPR, SEQ_BROKEN, SEQ_NOISE, SEQ_DEEP} seq_kind_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{"a",      1'b0, 1'b1, '{"a", 1'b0, 1'b0}},
        '{CH_PLUS,  1'b0, 1'b0, '0},
        '{"z",      1'b0, 1'b1, '{"z", 1'b0, 1'b0}},
        '{CH_STAR,  1'b0, 1'b0, '0},
        '{"A",      1'b0, 1'b1, '{"A", 1'b0, 1'b0}},
        '{CH_CARET, 1'b0, 1'b0, '0},
        '{"Z",      1'b0, 1'b1, '{"Z", 1'b0, 1'b0}},
        '{CH_MINUS, 1'b0, 1'b0, '0},
        '{"b",      1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{"c",      1'b0, 1'b0, '0},
        '{CH_CLOSE, 1'b0, 1'b0, '0},
        '{CH_OPEN,  1'b0, 1'b0, '0},
        '{"d",      1'b0, 1'b0, '0},
        '{CH_PLUS,  1'b0, 1'b0, '0},
        '{"e",      1'b0, 1'b0, '0},
        '{CH_CLOSE, 1'b0, 1'b0, '0},
        '{CH_OPEN,  1'b0, 1'b0, '0},
        '{CH_OPEN,  1'b1, 1'b1, '{CH_NUL, 1'b1, 1'b1}},
        '{"0",      1'b0, 1'b0, '0},
        '{8'hFF,    1'b0, 1'b0, '0},
        '{CH_NUL,   1'b0, 1'b0, '0},
        '{CH_CARET, 1'b0, 1'b0, '0},
        '{CH_CARET, 1'b0, 1'b0, '0},
        '{"x",      1'b1, 1'b0, '0},
        '{CH_CLOSE, 1'b1, 1'b1, '{CH_NUL, 1'b1, 1'b0}}
    };

    logic clk;
    logic rst_n;

    itp_in_if  infix_if ();
    itp_out_if postfix_if ();

    infix_to_postfix_converter_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .infix   (infix_if),
        .postfix (postfix_if)
    );

    // operator stack model
    logic [7:0]    shadow_stack [STACK_DEPTH];
    int            shadow_depth;
    logic          shadow_error;
    postfix_item_t predicted [$];
    postfix_item_t expected_postfix [$];
    postfix_item_t oldest;

    // table rows with a hand-written result
    logic          typed_armed;
    postfix_item_t typed_result;

    logic [7:0] infix_text [$];
    int         burst_left;
    int         items_in;
    int         items_out;
    int         terminators;
    int         deep_runs;
    int         fail_count;
    int         idle_cycles;
    rx_mode_t   rx_mode;
    logic [5:0] rx_phase;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int op_priority(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS: return 1;
            CH_STAR, CH_SLASH: return 2;
            CH_CARET:          return 3;
            default:           return -1;
        endcase
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void emit_postfix(input logic [7:0] c, input logic l);
        postfix_item_t r;
        r.ch   = c;
        r.last = l;
        r.err  = shadow_error;
        predicted.push_back(r);
    endfunction

    function automatic void push_operator(input logic [7:0] c);
        if (shadow_depth >= STACK_DEPTH)
        begin
            shadow_error = 1'b1;
        end
        else
        begin
            shadow_stack[shadow_depth] = c;
            shadow_depth++;
        end
    endfunction

    function automatic void predict_postfix(input logic [7:0] c, input logic l);
        int pri;
        if (is_alpha(c))
        begin
            emit_postfix(c, 1'b0);
        end
        else if (c == CH_OPEN)
        begin
            push_operator(c);
        end
        else if (c == CH_CLOSE)
        begin
            while (shadow_depth > 0 && shadow_stack[shadow_depth - 1] != CH_OPEN)
            begin
                shadow_depth--;
                emit_postfix(shadow_stack[shadow_depth], 1'b0);
            end
            if (shadow_depth > 0)
                shadow_depth--;
        end
        else
        begin
            pri = op_priority(c);
            while (shadow_depth > 0 && shadow_stack[shadow_depth - 1] != CH_OPEN &&
                   pri <= op_priority(shadow_stack[shadow_depth - 1]))
            begin
                shadow_depth--;
                emit_postfix(shadow_stack[shadow_depth], 1'b0);
            end
            push_operator(c);
        end
        if (l)
        begin
            while (shadow_depth > 0)
            begin
                shadow_depth--;
                if (shadow_stack[shadow_depth] == CH_OPEN)
                    shadow_error = 1'b1;
                else
                    emit_postfix(shadow_stack[shadow_depth], 1'b0);
            end
            emit_postfix(CH_NUL, 1'b1);
            shadow_error = 1'b0;
        end
    endfunction

    // predict on every accepted infix item, check every accepted postfix item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (infix_if.valid && infix_if.ready)
            begin
                items_in++;
                predicted.delete();
                predict_postfix(infix_if.in_char, infix_if.in_last);
                if (typed_armed)
                begin
                    predicted.delete();
                    predicted.push_back(typed_result);
                end
                while (predicted.size() > 0)
                    expected_postfix.push_back(predicted.pop_front());
            end
            if (postfix_if.valid && postfix_if.ready)
            begin
                items_out++;
                if (postfix_if.out_last)
                    terminators++;
                if (expected_postfix.size() == 0)
                begin
                    $error("unexpected postfix item: char 0x%02h last %0b error %0b",
                           postfix_if.out_char, postfix_if.out_last, postfix_if.out_error);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_postfix.pop_front();
                    if (postfix_if.out_char !== oldest.ch)
                    begin
                        $error("out_char mismatch: expected 0x%02h, actual 0x%02h",
                               oldest.ch, postfix_if.out_char);
                        fail_count++;
                    end
                    if (postfix_if.out_last !== oldest.last)
                    begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               oldest.last, postfix_if.out_last);
                        fail_count++;
                    end
                    if (postfix_if.out_error !== oldest.err)
                    begin
                        $error("out_error mismatch: expected %0b, actual %0b",
                               oldest.err, postfix_if.out_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((infix_if.valid && infix_if.ready) || (postfix_if.valid && postfix_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without an accepted item", IDLE_LIMIT);
            $display("** infix_to_postfix_converter_unit: FAILED **");
            $finish;
        end
    end

    // postfix receiver, stall mode picked anew each time rx_phase wraps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_phase <= rx_phase + 6'd1;
            if (rx_phase == '0)
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:     postfix_if.ready <= 1'b1;
                RX_RANDOM:   postfix_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   postfix_if.ready <= ($urandom_range(0, 3) == 0);
                default:     postfix_if.ready <= rx_phase[2];
            endcase
        end
    end

    task automatic send_char(input logic [7:0] c, input logic l,
                             input logic has_typed = 1'b0,
                             input postfix_item_t typed = '0);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                infix_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        typed_armed      = has_typed;
        typed_result     = typed;
        infix_if.valid   <= 1'b1;
        infix_if.in_char <= c;
        infix_if.in_last <= l;
        do @(posedge clk); while (!infix_if.ready);
    endtask

    task automatic send_text(input logic mark_last);
        for (int i = 0; i < infix_text.size(); i++)
            send_char(infix_text[i], mark_last && (i == infix_text.size() - 1));
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    function automatic void build_expression();
        int terms;
        int opens;
        infix_text.delete();
        opens = 0;
        terms = $urandom_range(1, 6);
        for (int i = 0; i < terms; i++)
        begin
            while (opens < 5 && $urandom_range(0, 3) == 0)
            begin
                infix_text.push_back(CH_OPEN);
                opens++;
            end
            infix_text.push_back(random_letter());
            while (opens > 0 && $urandom_range(0, 2) == 0)
            begin
                infix_text.push_back(CH_CLOSE);
                opens--;
            end
            if (i < terms - 1)
                infix_text.push_back(random_operator());
        end
        // mostly closed, sometimes a '(' is left open
        while (opens > 0 && $urandom_range(0, 7) != 0)
        begin
            infix_text.push_back(CH_CLOSE);
            opens--;
        end
    endfunction

    function automatic void build_broken();
        int len;
        infix_text.delete();
        len = $urandom_range(1, 8);
        repeat (len)
        begin
            case ($urandom_range(0, 4))
                0:       infix_text.push_back(random_letter());
                1:       infix_text.push_back(CH_OPEN);
                2:       infix_text.push_back(CH_CLOSE);
                3:       infix_text.push_back(8'($urandom_range(0, 255)));
                default: infix_text.push_back(random_operator());
            endcase
        end
    endfunction

    function automatic void build_noise();
        int len;
        infix_text.delete();
        len = $urandom_range(1, 6);
        repeat (len)
            infix_text.push_back(8'($urandom_range(0, 255)));
    endfunction

    // nesting around the stack depth, sometimes past it
    function automatic void build_deep();
        int len;
        infix_text.delete();
        len = STACK_DEPTH - 2 + $urandom_range(0, 6);
        infix_text.push_back(CH_OPEN);
        for (int i = 1; i < len; i++)
        begin
            if (infix_text[i - 1] == CH_OPEN && $urandom_range(0, 1))
                infix_text.push_back(random_operator());
            else
                infix_text.push_back(CH_OPEN);
        end
        infix_text.push_back(random_letter());
    endfunction

    initial
    begin
        seq_kind_t kind;
        int        roll;
        int        random_items;
        clk               = 1'b0;
        rst_n             = 1'b0;
        infix_if.valid    = 1'b0;
        infix_if.in_char  = '0;
        infix_if.in_last  = 1'b0;
        postfix_if.ready  = 1'b0;
        typed_armed       = 1'b0;
        typed_result      = '0;
        shadow_depth      = 0;
        shadow_error      = 1'b0;
        burst_left        = 0;
        items_in          = 0;
        items_out         = 0;
        terminators       = 0;
        deep_runs         = 0;
        fail_count        = 0;
        idle_cycles       = 0;
        rx_mode           = RX_OPEN;
        rx_phase          = '0;
        random_items      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
            send_char(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);

        while (random_items < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 15);
            if (deep_runs == 0 || roll == 15)
                kind = SEQ_DEEP;
            else if (roll < 10)
                kind = SEQ_EXPR;
            else if (roll < 13)
                kind = SEQ_BROKEN;
            else
                kind = SEQ_NOISE;
            case (kind)
                SEQ_EXPR:
                begin
                    build_expression();
                    send_text(1'b1);
                end
                SEQ_BROKEN:
                begin
                    build_broken();
                    send_text(1'($urandom_range(0, 1)));
                end
                SEQ_NOISE:
                begin
                    build_noise();
                    send_text(1'($urandom_range(0, 1)));
                end
                default:
                begin
                    build_deep();
                    deep_runs++;
                    send_text($urandom_range(0, 3) != 0);
                end
            endcase
            random_items += infix_text.size();
        end

        @(negedge clk);
        infix_if.valid   <= 1'b0;
        infix_if.in_last <= 1'b0;
        typed_armed      = 1'b0;
        while (expected_postfix.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d infix items (%0d from the table), %0d postfix items checked",
                 items_in, NUM_ROWS, items_out);
        $display("%0d expressions terminated, %0d deep nesting runs", terminators, deep_runs);
        if (fail_count == 0)
            $display("** infix_to_postfix_converter_unit: PASSED **");
        else
            $display("** infix_to_postfix_converter_unit: FAILED **");
        $finish;
    end

endmodule
